// ===== hdl/iaeval_pkg.sv =====
`default_nettype none

package iaeval_pkg;

   localparam int unsigned DATA_W = 32;
   localparam int unsigned CNT_W  = $clog2(DATA_W);

   localparam logic [7:0] CHAR_PLUS   = 8'h2b;
   localparam logic [7:0] CHAR_MINUS  = 8'h2d;
   localparam logic [7:0] CHAR_TIMES  = 8'h2a;
   localparam logic [7:0] CHAR_DIVIDE = 8'h2f;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_CR     = 8'h0d;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;

   typedef enum logic [2:0] {
      OP_PLUS,
      OP_MINUS,
      OP_TIMES,
      OP_DIVIDE,
      OP_OTHER
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLOSE,
      ST_MUL,
      ST_DIV,
      ST_DIV_FIX,
      ST_EMIT
   } state_type;

   function automatic op_type op_code(input logic [7:0] c);
      op_type op;
      case (c)
         CHAR_PLUS:   op = OP_PLUS;
         CHAR_MINUS:  op = OP_MINUS;
         CHAR_TIMES:  op = OP_TIMES;
         CHAR_DIVIDE: op = OP_DIVIDE;
         default:     op = OP_OTHER;
      endcase
      return op;
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c inside {[CHAR_ZERO:CHAR_NINE]};
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return c inside {[CHAR_TAB:CHAR_CR], CHAR_SPACE};
   endfunction

endpackage

`default_nettype wire

// ===== hdl/infix_arith_expression_eval.sv =====
`default_nettype none

// Evaluates an infix +, -, *, / expression sent one ASCII character per word, with
// req_last_char on the final character; one result word (32-bit wrapped sum and a
// divide-by-zero flag) follows the final character. An operator closes the pending
// number: * runs a shift-and-add multiplier, one multiplier bit per cycle, and / a
// restoring divider, one quotient bit per cycle, plus a sign fix; a divide by zero
// skips the divider. The final character adds one more closing under the operator
// pending after it, and the result register is then loaded in ST_EMIT once it is
// free. The result register is separate from the evaluator state, so a new expression
// may start while the previous result is still stalled.
module infix_arith_expression_eval
   import iaeval_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [7:0]               req_char_code,
   input  wire logic                     req_last_char,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic signed [DATA_W-1:0]      rsp_value,
   output logic                          rsp_div_by_zero
);

   state_type           state_ff, state_in;
   logic [DATA_W-1:0]   sum_ff, sum_in;
   logic [DATA_W-1:0]   open_ff, open_in;
   logic [DATA_W-1:0]   num_ff, num_in;
   logic [DATA_W-1:0]   acc_ff, acc_in;
   op_type              op_ff, op_in;
   op_type              new_op_ff, new_op_in;
   logic                is_op_ff, is_op_in;
   logic                dz_ff, dz_in;
   logic [1:0]          closes_ff, closes_in;
   logic                last_ff, last_in;
   logic                neg_ff, neg_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0]  rsp_value_ff, rsp_value_in;
   logic                      rsp_dz_ff, rsp_dz_in;

   logic                req_take;
   logic                rsp_free;
   logic                close_done;
   logic                mul_last;
   logic                div_last;
   logic [DATA_W-1:0]   mul_sum;
   logic [DATA_W-1:0]   div_shift;
   logic [DATA_W:0]     div_trial;
   logic                div_ge;
   logic [3:0]          digit;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign mul_last  = (cnt_ff == CNT_W'(DATA_W - 1));
   assign div_last  = mul_last;

   assign digit     = 4'(req_char_code - CHAR_ZERO);

   // one multiplier bit per cycle
   assign mul_sum   = acc_ff + (num_ff[0] ? open_ff : '0);

   // one quotient bit per cycle; dividend shifts out of open_ff as quotient shifts in
   assign div_shift = {acc_ff[DATA_W-2:0], open_ff[DATA_W-1]};
   assign div_trial = {1'b0, div_shift} - {1'b0, num_ff};
   assign div_ge    = !div_trial[DATA_W];

   always_comb begin
      close_done = 1'b0;
      case (state_ff)
         ST_CLOSE:   close_done = (op_ff != OP_TIMES) &&
                                  !((op_ff == OP_DIVIDE) && (num_ff != '0));
         ST_MUL:     close_done = mul_last;
         ST_DIV_FIX: close_done = 1'b1;
         default:    close_done = 1'b0;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_last_char || (!is_digit(req_char_code) && !is_space(req_char_code)))
                  state_in = ST_CLOSE;
            end
         end
         ST_CLOSE: begin
            if (op_ff == OP_TIMES)
               state_in = ST_MUL;
            else if ((op_ff == OP_DIVIDE) && (num_ff != '0))
               state_in = ST_DIV;
         end
         ST_MUL: begin
            if (mul_last)
               state_in = ST_IDLE;
         end
         ST_DIV: begin
            if (div_last)
               state_in = ST_DIV_FIX;
         end
         ST_DIV_FIX: state_in = ST_IDLE;
         ST_EMIT: begin
            if (rsp_free)
               state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
      if (close_done) begin
         if (closes_ff != 2'd1)
            state_in = ST_CLOSE;
         else if (last_ff)
            state_in = ST_EMIT;
         else
            state_in = ST_IDLE;
      end
   end

   // datapath and outputs
   always_comb begin
      sum_in       = sum_ff;
      open_in      = open_ff;
      num_in       = num_ff;
      acc_in       = acc_ff;
      op_in        = op_ff;
      new_op_in    = new_op_ff;
      is_op_in     = is_op_ff;
      dz_in        = dz_ff;
      closes_in    = closes_ff;
      last_in      = last_ff;
      neg_in       = neg_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_value_in = rsp_value_ff;
      rsp_dz_in    = rsp_dz_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               last_in   = req_last_char;
               new_op_in = op_code(req_char_code);
               if (is_digit(req_char_code)) begin
                  num_in    = {num_ff[DATA_W-4:0], 3'b000} + {num_ff[DATA_W-2:0], 1'b0}
                              + DATA_W'(digit);
                  is_op_in  = 1'b0;
                  closes_in = req_last_char ? 2'd1 : 2'd0;
               end else if (is_space(req_char_code)) begin
                  is_op_in  = 1'b0;
                  closes_in = req_last_char ? 2'd1 : 2'd0;
               end else begin
                  is_op_in  = 1'b1;
                  closes_in = req_last_char ? 2'd2 : 2'd1;
               end
            end
         end
         ST_CLOSE: begin
            cnt_in = '0;
            acc_in = '0;
            case (op_ff)
               OP_PLUS: begin
                  sum_in  = sum_ff + open_ff;
                  open_in = num_ff;
                  num_in  = '0;
               end
               OP_MINUS: begin
                  sum_in  = sum_ff + open_ff;
                  open_in = '0 - num_ff;
                  num_in  = '0;
               end
               OP_TIMES: ;
               OP_DIVIDE: begin
                  if (num_ff == '0) begin
                     open_in = '0;
                     dz_in   = 1'b1;
                  end else begin
                     neg_in  = open_ff[DATA_W-1] ^ num_ff[DATA_W-1];
                     open_in = open_ff[DATA_W-1] ? ('0 - open_ff) : open_ff;
                     num_in  = num_ff[DATA_W-1] ? ('0 - num_ff) : num_ff;
                  end
               end
               default: num_in = '0;
            endcase
         end
         ST_MUL: begin
            cnt_in = cnt_ff + 1'b1;
            acc_in = mul_sum;
            if (mul_last) begin
               open_in = mul_sum;
               num_in  = '0;
            end else begin
               open_in = {open_ff[DATA_W-2:0], 1'b0};
               num_in  = {1'b0, num_ff[DATA_W-1:1]};
            end
         end
         ST_DIV: begin
            cnt_in  = cnt_ff + 1'b1;
            acc_in  = div_ge ? div_trial[DATA_W-1:0] : div_shift;
            open_in = {open_ff[DATA_W-2:0], div_ge};
         end
         ST_DIV_FIX: begin
            open_in = neg_ff ? ('0 - open_ff) : open_ff;
            num_in  = '0;
         end
         ST_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = signed'(sum_ff + open_ff);
               rsp_dz_in    = dz_ff;
               sum_in       = '0;
               open_in      = '0;
               num_in       = '0;
               op_in        = OP_PLUS;
               dz_in        = 1'b0;
            end
         end
         default: ;
      endcase

      if (close_done) begin
         closes_in = closes_ff - 2'd1;
         // an operator word sets the pending operator after its own closing
         if (is_op_ff) begin
            op_in    = new_op_ff;
            is_op_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_ff       <= '0;
         open_ff      <= '0;
         num_ff       <= '0;
         op_ff        <= OP_PLUS;
         is_op_ff     <= 1'b0;
         dz_ff        <= 1'b0;
         closes_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         open_ff      <= open_in;
         num_ff       <= num_in;
         op_ff        <= op_in;
         is_op_ff     <= is_op_in;
         dz_ff        <= dz_in;
         closes_ff    <= closes_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff       <= acc_in;
      new_op_ff    <= new_op_in;
      last_ff      <= last_in;
      neg_ff       <= neg_in;
      cnt_ff       <= cnt_in;
      rsp_value_ff <= rsp_value_in;
      rsp_dz_ff    <= rsp_dz_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_value       = rsp_value_ff;
   assign rsp_div_by_zero = rsp_dz_ff;

   a_close_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLOSE) |-> (closes_ff != 2'd0))
      else $error("closing started with no closing pending");

   a_div_remainder: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (acc_ff < num_ff))
      else $error("divider remainder not below divisor");

   a_iter_count: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_MUL) || (state_ff == ST_DIV)) && !mul_last
      |=> (state_ff == $past(state_ff)) && (cnt_ff == CNT_W'($past(cnt_ff) + 1'b1)))
      else $error("serial unit left its loop early");

   a_emit_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) && rsp_free
      |=> rsp_valid_ff && (sum_ff == '0) && (open_ff == '0) && (num_ff == '0)
          && (op_ff == OP_PLUS) && !dz_ff && (state_ff == ST_IDLE))
      else $error("evaluator state not cleared after result");

endmodule

`default_nettype wire
